FILE: sv/iaf_pkg.sv
package iaf_pkg;

  localparam int MAX_CHARS   = 24;
  localparam int DIGIT_SLOTS = 20;
  localparam int VALUE_W     = 64;
  localparam int WIDTH_IN_W  = 5;
  localparam int CNT_W       = $clog2(VALUE_W);
  localparam int SLOT_W      = $clog2(MAX_CHARS);
  localparam int W_W         = $clog2(MAX_CHARS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] HEX_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [7:0] HEX_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic clear;      // zero the digit
    logic bit_shift;  // take one value bit from below
    logic dig_shift;  // take the whole digit from below
    logic dec;        // add-3 correction for decimal digits
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    digit_char = upper ? HEX_UPPER[d] : HEX_LOWER[d];
  endfunction

endpackage

FILE: sv/iaf_digit_cell.sv
module iaf_digit_cell import iaf_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       cin,
  input  logic [3:0] din,
  output logic [3:0] digit,
  output logic       cout
);

  logic [3:0] corr;

  // decimal digits of five or more get +3 before doubling
  always_comb begin
    corr = digit;
    if (ctl.dec && (digit >= 4'd5)) begin
      corr = digit + 4'd3;
    end
  end

  assign cout = corr[3];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= 4'd0;
    end else if (ctl.bit_shift) begin
      digit <= {corr[2:0], cin};
    end else if (ctl.dig_shift) begin
      digit <= din;
    end
  end

endmodule

FILE: sv/iaf_digit_chain.sv
module iaf_digit_chain import iaf_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,
  output logic [3:0] top_digit
);

  logic [3:0] digit [DIGIT_SLOTS];
  logic       carry [DIGIT_SLOTS];

  for (genvar i = 0; i < DIGIT_SLOTS; i++) begin : g_cell
    logic       cin_i;
    logic [3:0] din_i;

    if (i == 0) begin : g_first
      assign cin_i = bit_in;
      assign din_i = 4'd0;
    end else begin : g_rest
      assign cin_i = carry[i-1];
      assign din_i = digit[i-1];
    end

    iaf_digit_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .cin   (cin_i),
      .din   (din_i),
      .digit (digit[i]),
      .cout  (carry[i])
    );
  end

  assign top_digit = digit[DIGIT_SLOTS-1];

endmodule

FILE: sv/integer_to_ascii_formatter.sv
// Each item shifts all 64 value bits through the digit cell chain, emits a minus sign when negative,
//   then walks the character slots from the widest field down, one slot per cycle; a slot that holds
//   a padding or digit character waits while the output stalls.
// Characters leave at up to one per cycle; input is stalled while an item is in flight.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops any pending output.
module integer_to_ascii_formatter import iaf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_W-1:0]    value,
  input  logic                  signed_mode,
  input  logic                  base_hex,
  input  logic                  upper_case,
  input  logic [WIDTH_IN_W-1:0] min_width,
  input  logic                  zero_pad,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            ch,
  output logic                  last
);

  state_t             state;
  logic [VALUE_W-1:0] val;        // bits still to feed into the cell chain, MSB first
  logic [CNT_W-1:0]   bit_cnt;
  logic [SLOT_W-1:0]  slot;       // character slot, counted down from the widest field
  logic [W_W-1:0]     width;      // sign-adjusted minimum width
  logic               neg;
  logic               dec;
  logic               upper;
  logic               pad_zero;
  logic               seen;       // a digit has been emitted, so later zeros are digits

  logic               accept;
  logic               can_emit;
  logic [3:0]         top_digit;
  logic               in_chain;
  logic               is_digit;
  logic               is_pad;
  logic               step;
  logic               fire;
  logic [7:0]         fire_ch;
  logic               fire_last;
  logic [W_W-1:0]     width_sat;
  logic               value_neg;
  cell_ctl_t          ctl;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // output register is free, or its transfer happens this cycle
  assign can_emit = !out_valid || !out_stall;

  assign value_neg = signed_mode && value[VALUE_W-1];

  always_comb begin
    width_sat = W_W'(min_width);
    if (width_sat > W_W'(MAX_CHARS)) begin
      width_sat = W_W'(MAX_CHARS);
    end
    // the minus sign takes one place of the width
    if (value_neg && (width_sat != '0)) begin
      width_sat = width_sat - W_W'(1);
    end
  end

  // Character slot decode: slots above the digit count are padding while below the width,
  // otherwise skipped. The lowest slot always holds a digit.
  assign in_chain = (slot < SLOT_W'(DIGIT_SLOTS));
  assign is_digit = in_chain && (seen || (top_digit != 4'd0) || (slot == '0));
  assign is_pad   = !is_digit && (W_W'(slot) < width);
  assign step     = (state == ST_EMIT) && (!(is_digit || is_pad) || can_emit);

  always_comb begin
    fire      = 1'b0;
    fire_ch   = CHAR_MINUS;
    fire_last = 1'b0;
    case (state)
      ST_SIGN: begin
        fire = can_emit;
      end
      ST_EMIT: begin
        fire      = (is_digit || is_pad) && can_emit;
        fire_last = (slot == '0);
        if (is_digit) begin
          fire_ch = digit_char(top_digit, upper);
        end else begin
          fire_ch = pad_zero ? CHAR_ZERO : CHAR_SPACE;
        end
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl.clear     = accept;
    ctl.bit_shift = (state == ST_CONV);
    ctl.dig_shift = step && in_chain;
    ctl.dec       = dec;
  end

  iaf_digit_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .bit_in    (val[VALUE_W-1]),
    .top_digit (top_digit)
  );

  // Sequencer: load, shift all value bits through the chain, optional sign, then slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt == CNT_W'(VALUE_W - 1)) begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (can_emit) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (step && (slot == '0)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item registers: load the operand and format bits on accept; the operand then shifts left during conversion.
  always_ff @(posedge clk) begin
    if (accept) begin
      val      <= value_neg ? (~value + VALUE_W'(1)) : value;
      bit_cnt  <= '0;
      width    <= width_sat;
      neg      <= value_neg;
      dec      <= signed_mode || !base_hex;
      upper    <= !signed_mode && base_hex && upper_case;
      pad_zero <= zero_pad;
    end else if (state == ST_CONV) begin
      val     <= val << 1;
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
  end

  // Slot walk: start at the widest field, advance one slot per step.
  always_ff @(posedge clk) begin
    if (state == ST_CONV) begin
      slot <= SLOT_W'(MAX_CHARS - 1);
      seen <= 1'b0;
    end else if (step) begin
      slot <= slot - SLOT_W'(1);
      if (is_digit) begin
        seen <= 1'b1;
      end
    end
  end

  // Output register: load only when free or being drained, so a stalled character holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ch   <= fire_ch;
      last <= fire_last;
    end
  end

endmodule
